FILE: rtl/jev_pkg.sv
// shared types for the 3x3 jacobi eigen solver
// arithmetic unit op codes and request struct; no dependencies
`default_nettype none

package jev_pkg;

    localparam int OPA_W = 68;
    localparam int OPB_W = 37;
    localparam int RES_W = 72;

    typedef enum logic [1:0] {
        ARITH_MUL,
        ARITH_MULQ,
        ARITH_DIV,
        ARITH_SQRT
    } arith_op_t;

    typedef struct packed {
        arith_op_t          op;
        logic [OPA_W-1:0]   opa;
        logic [OPB_W-1:0]   opb;
    } arith_req_t;

endpackage

`default_nettype wire

FILE: rtl/jacobi_eigen_3x3_top.sv
// each nonzero rotation runs on the shared unit: two divides, two square roots and 21 multiplies
// throughput: one matrix at a time, busy stays high until the last eigenpair is out
// async active-low reset clears state and loads max_sweeps 100, converge_tol 1, symmetry_tol 0
// results are single-cycle strobes on done; the receiver cannot stall, depends on jev_pkg, jev_arith
`default_nettype none

module jacobi_eigen_3x3_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] elem_r0c0,
    input  wire logic signed [31:0] elem_r0c1,
    input  wire logic signed [31:0] elem_r0c2,
    input  wire logic signed [31:0] elem_r1c0,
    input  wire logic signed [31:0] elem_r1c1,
    input  wire logic signed [31:0] elem_r1c2,
    input  wire logic signed [31:0] elem_r2c0,
    input  wire logic signed [31:0] elem_r2c1,
    input  wire logic signed [31:0] elem_r2c2,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [16:0]        cfg_data,
    output logic                    done,
    output logic signed [35:0]      eigenvalue,
    output logic signed [31:0]      vec_x,
    output logic signed [31:0]      vec_y,
    output logic signed [31:0]      vec_z,
    output logic                    is_last,
    output logic                    not_symmetric
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SYM,
        S_SWEEP,
        S_ROT0,
        S_SQD,
        S_SQE,
        S_SQRTR,
        S_DIVT,
        S_SQT,
        S_SQRTH,
        S_DIVC,
        S_MULS,
        S_MULTAP,
        S_GRP,
        S_NEXTPAIR,
        S_NSQ,
        S_NSQRT,
        S_NDIV,
        S_EMIT
    } state_t;

    localparam logic [1:0] CFG_MAX_SWEEPS   = 2'd0;
    localparam logic [1:0] CFG_CONVERGE_TOL = 2'd1;
    localparam logic [1:0] CFG_SYMMETRY_TOL = 2'd2;

    localparam logic signed [38:0] EMAX = 39'sh07_FFFF_FFFF;
    localparam logic signed [38:0] EMIN = 39'sh78_0000_0000;
    localparam logic signed [35:0] VONE = 36'sh0_4000_0000;

    state_t                 state_reg;
    logic                   wait_reg;
    logic signed [35:0]     a_reg [9];
    logic signed [35:0]     v_reg [9];
    logic [1:0]             pair_reg;
    logic [6:0]             sw_reg;
    logic [30:0]            dd_reg;
    logic [30:0]            ee_reg;
    logic                   tneg_reg;
    logic [63:0]            sq_reg;
    logic [32:0]            den_reg;
    logic [30:0]            tm_reg;
    logic [31:0]            h_reg;
    logic [30:0]            c_reg;
    logic signed [31:0]     t_reg;
    logic signed [31:0]     s_reg;
    logic signed [37:0]     m0_reg;
    logic signed [37:0]     m1_reg;
    logic signed [37:0]     m2_reg;
    logic [3:0]             gidx_reg;
    logic [1:0]             kout_reg;
    logic [1:0]             nidx_reg;
    logic [31:0]            len_reg;
    logic [31:0]            comp_reg [3];
    logic                   done_reg;
    logic signed [35:0]     eig_reg;
    logic signed [31:0]     vx_reg;
    logic signed [31:0]     vy_reg;
    logic signed [31:0]     vz_reg;
    logic                   last_reg;
    logic                   nsym_reg;
    logic [6:0]             max_sweeps_reg;
    logic [16:0]            converge_tol_reg;
    logic [16:0]            symmetry_tol_reg;

    jev_pkg::arith_req_t    areq;
    logic                   arith_go;
    logic                   arith_done;
    logic [71:0]            arith_res;

    logic [1:0]             p_idx;
    logic [1:0]             q_idx;
    logic [1:0]             k_idx;
    logic signed [35:0]     app;
    logic signed [35:0]     aqq;
    logic signed [35:0]     apq;
    logic signed [36:0]     d_val;
    logic signed [36:0]     e_val;
    logic [36:0]            ud;
    logic [36:0]            ue;
    logic [36:0]            mx;
    logic [2:0]             sh;
    logic [1:0]             grp;
    logic [1:0]             sel;
    logic [1:0]             vrow;
    logic signed [35:0]     xp;
    logic signed [35:0]     xq;
    logic signed [35:0]     gx;
    logic signed [31:0]     gk;
    logic [1:0]             pos0;
    logic [1:0]             pos1;
    logic [1:0]             pos2;
    logic [1:0]             col;
    logic signed [35:0]     vn;
    logic [35:0]            vn_mag;
    logic [37:0]            off_sum;
    logic                   sym_fail;
    logic                   op_state;
    logic signed [38:0]     newp;
    logic signed [38:0]     newq;
    logic signed [37:0]     res38;
    logic signed [38:0]     tap_lo;
    logic signed [38:0]     tap_hi;
    logic [31:0]            tm_ext;

    function automatic logic [3:0] mi(logic [1:0] r, logic [1:0] c);
        return 4'({2'b0, r} * 4'd3 + {2'b0, c});
    endfunction

    function automatic logic [35:0] mag36(logic signed [35:0] x);
        return x[35] ? 36'(-x) : 36'(x);
    endfunction

    function automatic logic [36:0] mag37(logic signed [36:0] x);
        return x[36] ? 37'(-x) : 37'(x);
    endfunction

    function automatic logic signed [35:0] sat36(logic signed [38:0] x);
        logic signed [35:0] r;
        if (x > EMAX)
            r = EMAX[35:0];
        else if (x < EMIN)
            r = EMIN[35:0];
        else
            r = x[35:0];
        return r;
    endfunction

    // pair roles and rotation operands
    always_comb
    begin
        unique case (pair_reg)
            2'd0:
            begin
                p_idx = 2'd0;
                q_idx = 2'd1;
                k_idx = 2'd2;
            end
            2'd1:
            begin
                p_idx = 2'd0;
                q_idx = 2'd2;
                k_idx = 2'd1;
            end
            default:
            begin
                p_idx = 2'd1;
                q_idx = 2'd2;
                k_idx = 2'd0;
            end
        endcase
        app   = a_reg[mi(p_idx, p_idx)];
        aqq   = a_reg[mi(q_idx, q_idx)];
        apq   = a_reg[mi(p_idx, q_idx)];
        d_val = 37'(aqq) - 37'(app);
        e_val = {apq, 1'b0};
        ud    = mag37(d_val);
        ue    = mag37(e_val);
        mx    = (ud > ue) ? ud : ue;
        priority if (mx[36]) sh = 3'd6;
        else if (mx[35])     sh = 3'd5;
        else if (mx[34])     sh = 3'd4;
        else if (mx[33])     sh = 3'd3;
        else if (mx[32])     sh = 3'd2;
        else if (mx[31])     sh = 3'd1;
        else                 sh = 3'd0;
    end

    // rotation of one row: four products per row
    assign grp  = gidx_reg[3:2];
    assign sel  = gidx_reg[1:0];
    assign vrow = grp - 2'd1;
    assign xp   = (grp == 2'd0) ? a_reg[mi(k_idx, p_idx)] : v_reg[mi(vrow, p_idx)];
    assign xq   = (grp == 2'd0) ? a_reg[mi(k_idx, q_idx)] : v_reg[mi(vrow, q_idx)];
    assign gx   = (sel == 2'd0 || sel == 2'd2) ? xp : xq;
    assign gk   = (sel == 2'd0 || sel == 2'd3) ? $signed({1'b0, c_reg}) : s_reg;

    assign res38  = arith_res[37:0];
    assign newp   = 39'(m0_reg) - 39'(m1_reg);
    assign newq   = 39'(m2_reg) + 39'(res38);
    assign tap_lo = 39'(app) - 39'(res38);
    assign tap_hi = 39'(aqq) + 39'(res38);
    assign tm_ext = {1'b0, arith_res[30:0]};

    // stable descending order of the diagonal
    assign pos0 = {1'b0, a_reg[4] > a_reg[0]} + {1'b0, a_reg[8] > a_reg[0]};
    assign pos1 = {1'b0, a_reg[0] >= a_reg[4]} + {1'b0, a_reg[8] > a_reg[4]};
    assign pos2 = {1'b0, a_reg[0] >= a_reg[8]} + {1'b0, a_reg[4] >= a_reg[8]};
    assign col  = (pos0 == kout_reg) ? 2'd0 : ((pos1 == kout_reg) ? 2'd1 : 2'd2);
    assign vn     = v_reg[mi(nidx_reg, col)];
    assign vn_mag = mag36(vn);

    assign off_sum = 38'(mag36(a_reg[1])) + 38'(mag36(a_reg[2])) + 38'(mag36(a_reg[5]));
    assign sym_fail =
        (mag37(37'(a_reg[1]) - 37'(a_reg[3])) > 37'(symmetry_tol_reg)) ||
        (mag37(37'(a_reg[2]) - 37'(a_reg[6])) > 37'(symmetry_tol_reg)) ||
        (mag37(37'(a_reg[5]) - 37'(a_reg[7])) > 37'(symmetry_tol_reg));

    // operands for the shared unit
    always_comb
    begin
        areq.op  = jev_pkg::ARITH_MUL;
        areq.opa = '0;
        areq.opb = '0;
        op_state = 1'b1;
        unique case (state_reg)
            S_SQD:
            begin
                areq.opa = 68'(dd_reg);
                areq.opb = 37'(dd_reg);
            end
            S_SQE:
            begin
                areq.opa = 68'(ee_reg);
                areq.opb = 37'(ee_reg);
            end
            S_SQT:
            begin
                areq.opa = 68'(tm_reg);
                areq.opb = 37'(tm_reg);
            end
            S_SQRTR, S_SQRTH, S_NSQRT:
            begin
                areq.op  = jev_pkg::ARITH_SQRT;
                areq.opa = 68'(sq_reg);
            end
            S_DIVT:
            begin
                areq.op  = jev_pkg::ARITH_DIV;
                areq.opa = (68'(ee_reg) << 30) + 68'(den_reg >> 1);
                areq.opb = 37'(den_reg);
            end
            S_DIVC:
            begin
                areq.op  = jev_pkg::ARITH_DIV;
                areq.opa = (68'(1) << 60) + 68'(h_reg >> 1);
                areq.opb = 37'(h_reg);
            end
            S_NDIV:
            begin
                areq.op  = jev_pkg::ARITH_DIV;
                areq.opa = 68'(64'({vn_mag, 30'b0}) + 64'(len_reg >> 1));
                areq.opb = 37'(len_reg);
            end
            S_MULS:
            begin
                areq.op  = jev_pkg::ARITH_MULQ;
                areq.opa = 68'($signed({1'b0, c_reg}));
                areq.opb = 37'(t_reg);
            end
            S_MULTAP:
            begin
                areq.op  = jev_pkg::ARITH_MULQ;
                areq.opa = 68'(apq);
                areq.opb = 37'(t_reg);
            end
            S_GRP:
            begin
                areq.op  = jev_pkg::ARITH_MULQ;
                areq.opa = 68'(gx);
                areq.opb = 37'(gk);
            end
            S_NSQ:
            begin
                areq.opa = 68'(vn);
                areq.opb = 37'(vn);
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
    end

    assign arith_go = op_state && !wait_reg && !(state_reg == S_NDIV && len_reg == 32'd0);

    jev_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (arith_go),
        .req   (areq),
        .done  (arith_done),
        .res   (arith_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wait_reg         <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                a_reg[i] <= '0;
                v_reg[i] <= '0;
            end
            pair_reg         <= '0;
            sw_reg           <= '0;
            dd_reg           <= '0;
            ee_reg           <= '0;
            tneg_reg         <= 1'b0;
            sq_reg           <= '0;
            den_reg          <= '0;
            tm_reg           <= '0;
            h_reg            <= '0;
            c_reg            <= '0;
            t_reg            <= '0;
            s_reg            <= '0;
            m0_reg           <= '0;
            m1_reg           <= '0;
            m2_reg           <= '0;
            gidx_reg         <= '0;
            kout_reg         <= '0;
            nidx_reg         <= '0;
            len_reg          <= '0;
            for (int i = 0; i < 3; i++)
                comp_reg[i] <= '0;
            done_reg         <= 1'b0;
            eig_reg          <= '0;
            vx_reg           <= '0;
            vy_reg           <= '0;
            vz_reg           <= '0;
            last_reg         <= 1'b0;
            nsym_reg         <= 1'b0;
            max_sweeps_reg   <= 7'd100;
            converge_tol_reg <= 17'd1;
            symmetry_tol_reg <= 17'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MAX_SWEEPS:   max_sweeps_reg   <= cfg_data[6:0];
                    CFG_CONVERGE_TOL: converge_tol_reg <= cfg_data;
                    CFG_SYMMETRY_TOL: symmetry_tol_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (arith_go)
                wait_reg <= 1'b1;
            else if (arith_done)
                wait_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg[0] <= 36'(elem_r0c0);
                        a_reg[1] <= 36'(elem_r0c1);
                        a_reg[2] <= 36'(elem_r0c2);
                        a_reg[3] <= 36'(elem_r1c0);
                        a_reg[4] <= 36'(elem_r1c1);
                        a_reg[5] <= 36'(elem_r1c2);
                        a_reg[6] <= 36'(elem_r2c0);
                        a_reg[7] <= 36'(elem_r2c1);
                        a_reg[8] <= 36'(elem_r2c2);
                        for (int i = 0; i < 9; i++)
                            v_reg[i] <= (i % 4 == 0) ? VONE : 36'sd0;
                        state_reg <= S_SYM;
                    end
                end
                S_SYM:
                begin
                    if (sym_fail)
                    begin
                        done_reg  <= 1'b1;
                        nsym_reg  <= 1'b1;
                        last_reg  <= 1'b1;
                        eig_reg   <= '0;
                        vx_reg    <= '0;
                        vy_reg    <= '0;
                        vz_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        sw_reg    <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    if (sw_reg >= max_sweeps_reg || off_sum < 38'(converge_tol_reg))
                    begin
                        kout_reg  <= '0;
                        nidx_reg  <= '0;
                        sq_reg    <= '0;
                        state_reg <= S_NSQ;
                    end
                    else
                    begin
                        pair_reg  <= '0;
                        state_reg <= S_ROT0;
                    end
                end
                S_ROT0:
                begin
                    if (apq == 36'sd0)
                        state_reg <= S_NEXTPAIR;
                    else
                    begin
                        dd_reg    <= 31'(ud >> sh);
                        ee_reg    <= 31'(ue >> sh);
                        tneg_reg  <= (d_val != 37'sd0) && (d_val[36] != e_val[36]);
                        state_reg <= S_SQD;
                    end
                end
                S_SQD:
                begin
                    if (arith_done)
                    begin
                        sq_reg    <= arith_res[63:0];
                        state_reg <= S_SQE;
                    end
                end
                S_SQE:
                begin
                    if (arith_done)
                    begin
                        sq_reg    <= sq_reg + arith_res[63:0];
                        state_reg <= S_SQRTR;
                    end
                end
                S_SQRTR:
                begin
                    if (arith_done)
                    begin
                        den_reg   <= 33'(dd_reg) + 33'(arith_res[31:0]);
                        state_reg <= S_DIVT;
                    end
                end
                S_DIVT:
                begin
                    if (arith_done)
                    begin
                        tm_reg    <= arith_res[30:0];
                        t_reg     <= tneg_reg ? $signed(32'(0) - tm_ext) : $signed(tm_ext);
                        state_reg <= S_SQT;
                    end
                end
                S_SQT:
                begin
                    if (arith_done)
                    begin
                        sq_reg    <= arith_res[63:0] + (64'(1) << 60);
                        state_reg <= S_SQRTH;
                    end
                end
                S_SQRTH:
                begin
                    if (arith_done)
                    begin
                        h_reg     <= arith_res[31:0];
                        state_reg <= S_DIVC;
                    end
                end
                S_DIVC:
                begin
                    if (arith_done)
                    begin
                        c_reg     <= arith_res[30:0];
                        state_reg <= S_MULS;
                    end
                end
                S_MULS:
                begin
                    if (arith_done)
                    begin
                        s_reg     <= $signed(arith_res[31:0]);
                        state_reg <= S_MULTAP;
                    end
                end
                S_MULTAP:
                begin
                    if (arith_done)
                    begin
                        a_reg[mi(p_idx, p_idx)] <= sat36(tap_lo);
                        a_reg[mi(q_idx, q_idx)] <= sat36(tap_hi);
                        a_reg[mi(p_idx, q_idx)] <= '0;
                        a_reg[mi(q_idx, p_idx)] <= '0;
                        gidx_reg                <= '0;
                        state_reg               <= S_GRP;
                    end
                end
                S_GRP:
                begin
                    if (arith_done)
                    begin
                        gidx_reg <= gidx_reg + 4'd1;
                        unique case (sel)
                            2'd0: m0_reg <= res38;
                            2'd1: m1_reg <= res38;
                            2'd2: m2_reg <= res38;
                            default:
                            begin
                                if (grp == 2'd0)
                                begin
                                    a_reg[mi(k_idx, p_idx)] <= sat36(newp);
                                    a_reg[mi(p_idx, k_idx)] <= sat36(newp);
                                    a_reg[mi(k_idx, q_idx)] <= sat36(newq);
                                    a_reg[mi(q_idx, k_idx)] <= sat36(newq);
                                end
                                else
                                begin
                                    v_reg[mi(vrow, p_idx)] <= newp[35:0];
                                    v_reg[mi(vrow, q_idx)] <= newq[35:0];
                                end
                                if (grp == 2'd3)
                                    state_reg <= S_NEXTPAIR;
                            end
                        endcase
                    end
                end
                S_NEXTPAIR:
                begin
                    if (pair_reg == 2'd2)
                    begin
                        sw_reg    <= sw_reg + 7'd1;
                        state_reg <= S_SWEEP;
                    end
                    else
                    begin
                        pair_reg  <= pair_reg + 2'd1;
                        state_reg <= S_ROT0;
                    end
                end
                S_NSQ:
                begin
                    if (arith_done)
                    begin
                        sq_reg <= sq_reg + arith_res[63:0];
                        if (nidx_reg == 2'd2)
                        begin
                            nidx_reg  <= '0;
                            state_reg <= S_NSQRT;
                        end
                        else
                            nidx_reg <= nidx_reg + 2'd1;
                    end
                end
                S_NSQRT:
                begin
                    if (arith_done)
                    begin
                        len_reg   <= arith_res[31:0];
                        state_reg <= S_NDIV;
                    end
                end
                S_NDIV:
                begin
                    if (len_reg == 32'd0 || arith_done)
                    begin
                        if (len_reg == 32'd0)
                            comp_reg[nidx_reg] <= vn[31:0];
                        else if (vn[35])
                            comp_reg[nidx_reg] <= 32'(0) - arith_res[31:0];
                        else
                            comp_reg[nidx_reg] <= arith_res[31:0];
                        if (nidx_reg == 2'd2)
                        begin
                            nidx_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                            nidx_reg <= nidx_reg + 2'd1;
                    end
                end
                S_EMIT:
                begin
                    done_reg <= 1'b1;
                    eig_reg  <= a_reg[mi(col, col)];
                    vx_reg   <= $signed(comp_reg[0]);
                    vy_reg   <= $signed(comp_reg[1]);
                    vz_reg   <= $signed(comp_reg[2]);
                    last_reg <= (kout_reg == 2'd2);
                    nsym_reg <= 1'b0;
                    if (kout_reg == 2'd2)
                        state_reg <= S_IDLE;
                    else
                    begin
                        kout_reg  <= kout_reg + 2'd1;
                        sq_reg    <= '0;
                        state_reg <= S_NSQ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign eigenvalue    = eig_reg;
    assign vec_x         = vx_reg;
    assign vec_y         = vy_reg;
    assign vec_z         = vz_reg;
    assign is_last       = last_reg;
    assign not_symmetric = nsym_reg;

`ifndef SYNTH
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_last) |-> !busy)
        else $error("busy after last result");
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_last) |-> busy)
        else $error("idle between results of one matrix");
    a_nsym_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && not_symmetric) |-> (is_last && eigenvalue == 36'sd0))
        else $error("bad not-symmetric result");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");
`endif

endmodule

`default_nettype wire

FILE: rtl/jev_arith.sv
// shared multi-cycle arithmetic unit: multiply, q2.30 multiply, divide, square root
// depends on jev_pkg
`default_nettype none

module jev_arith (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire jev_pkg::arith_req_t          req,
    output logic                              done,
    output logic [jev_pkg::RES_W-1:0]         res
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL_LO,
        A_MUL_HI,
        A_MUL_FIN,
        A_DIV,
        A_SQRT
    } astate_t;

    localparam logic [6:0] DIV_LAST  = 7'(jev_pkg::OPA_W - 1);
    localparam logic [6:0] SQRT_LAST = 7'd31;

    astate_t                 state_reg;
    jev_pkg::arith_op_t      op_reg;
    logic                    neg_reg;
    logic [36:0]             mag_a_reg;
    logic [36:0]             mag_b_reg;
    logic [73:0]             acc_reg;
    logic [35:0]             rem_reg;
    logic [67:0]             nq_reg;
    logic [35:0]             den_reg;
    logic [6:0]              cnt_reg;
    logic [63:0]             sn_reg;
    logic [63:0]             sr_reg;
    logic [63:0]             sb_reg;
    logic                    done_reg;
    logic [71:0]             res_reg;

    logic [55:0]             plo;
    logic [54:0]             phi;
    logic [43:0]             rnd;
    logic [36:0]             cat;
    logic [37:0]             diff;
    logic                    div_ge;
    logic [63:0]             rb;
    logic                    sq_ge;
    logic [63:0]             sr_new;

    function automatic logic [36:0] mag37(logic signed [36:0] x);
        return x[36] ? 37'(-x) : 37'(x);
    endfunction

    assign plo    = 56'(mag_a_reg[18:0]) * 56'(mag_b_reg);
    assign phi    = 55'(mag_a_reg[36:19]) * 55'(mag_b_reg);
    assign rnd    = 44'((acc_reg + (74'(1) << 29)) >> 30);
    assign cat    = {rem_reg, nq_reg[67]};
    assign diff   = {1'b0, cat} - {2'b0, den_reg};
    assign div_ge = !diff[37];
    assign rb     = sr_reg + sb_reg;
    assign sq_ge  = sn_reg >= rb;
    assign sr_new = sq_ge ? ((sr_reg >> 1) + sb_reg) : (sr_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= jev_pkg::ARITH_MUL;
            neg_reg   <= 1'b0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            nq_reg    <= '0;
            den_reg   <= '0;
            cnt_reg   <= '0;
            sn_reg    <= '0;
            sr_reg    <= '0;
            sb_reg    <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (go)
                    begin
                        op_reg    <= req.op;
                        neg_reg   <= req.opa[36] ^ req.opb[36];
                        mag_a_reg <= mag37(req.opa[36:0]);
                        mag_b_reg <= mag37(req.opb);
                        nq_reg    <= req.opa;
                        den_reg   <= req.opb[35:0];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        sn_reg    <= req.opa[63:0];
                        sr_reg    <= '0;
                        sb_reg    <= 64'h4000_0000_0000_0000;
                        unique case (req.op)
                            jev_pkg::ARITH_DIV:  state_reg <= A_DIV;
                            jev_pkg::ARITH_SQRT: state_reg <= A_SQRT;
                            default:             state_reg <= A_MUL_LO;
                        endcase
                    end
                end
                A_MUL_LO:
                begin
                    acc_reg   <= 74'(plo);
                    state_reg <= A_MUL_HI;
                end
                A_MUL_HI:
                begin
                    acc_reg   <= acc_reg + (74'(phi) << 19);
                    state_reg <= A_MUL_FIN;
                end
                A_MUL_FIN:
                begin
                    if (op_reg == jev_pkg::ARITH_MULQ)
                        res_reg <= neg_reg ? (72'(0) - 72'(rnd)) : 72'(rnd);
                    else
                        res_reg <= acc_reg[71:0];
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV:
                begin
                    rem_reg <= div_ge ? diff[35:0] : cat[35:0];
                    nq_reg  <= {nq_reg[66:0], div_ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        res_reg   <= 72'({nq_reg[66:0], div_ge});
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_SQRT:
                begin
                    if (sq_ge)
                        sn_reg <= sn_reg - rb;
                    sr_reg  <= sr_new;
                    sb_reg  <= sb_reg >> 2;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == SQRT_LAST)
                    begin
                        res_reg   <= 72'(sr_new);
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

`ifndef SYNTH
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == A_IDLE)
        else $error("request while unit busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == A_IDLE)
        else $error("done while still working");
`endif

endmodule

`default_nettype wire
